// File: hdl/pid_position_regulator_top_macros.svh
// assertion macros for the regulator rtl
// clock and reset names are fixed to i_clk and i_rst_n of the including module
`ifndef PID_POSITION_REGULATOR_TOP_MACROS_SVH
`define PID_POSITION_REGULATOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define PPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ppr_pkg.sv
// shared types and constants of the pid position regulator
// no dependencies
package ppr_pkg;

    localparam int GAIN_BITS = 24;
    localparam int INT_W     = 11;
    localparam int DRIVE_W   = 8;
    localparam int BAND_W    = 23;
    localparam int TICK_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int INTEGRAL_LIMIT = 1000;
    localparam int DRIVE_LIMIT    = 127;

    localparam logic [BAND_W-1:0] SETTLE_BAND_RST = BAND_W'(800);
    localparam logic [TICK_W-1:0] TICK_LIMIT_RST  = TICK_W'(1000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET   = 3'd0,
        CFG_GAIN_P   = 3'd1,
        CFG_GAIN_I   = 3'd2,
        CFG_GAIN_D   = 3'd3,
        CFG_SETTLE   = 3'd4,
        CFG_TICK_LIM = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] gain_p;
        logic signed [GAIN_BITS-1:0] gain_i;
        logic signed [GAIN_BITS-1:0] gain_d;
        logic        [BAND_W-1:0]    settle_band;
        logic        [TICK_W-1:0]    tick_limit;
    } t_cfg;

endpackage

// File: hdl/ppr_cfg_regs.sv
// configuration register file of the regulator
// depends on ppr_pkg
module ppr_cfg_regs #(
    parameter int POSITION_BITS = 24,
    parameter int CFG_W         = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]                    i_cfg_data,
    output logic signed [POSITION_BITS-1:0]     o_target,
    output ppr_pkg::t_cfg                       o_cfg
);
    import ppr_pkg::*;

    logic signed [POSITION_BITS-1:0] r_target;
    t_cfg                            r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target          <= '0;
            r_cfg.gain_p      <= '0;
            r_cfg.gain_i      <= '0;
            r_cfg.gain_d      <= '0;
            r_cfg.settle_band <= SETTLE_BAND_RST;
            r_cfg.tick_limit  <= TICK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET:   r_target          <= i_cfg_data[POSITION_BITS-1:0];
                CFG_GAIN_P:   r_cfg.gain_p      <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_I:   r_cfg.gain_i      <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_D:   r_cfg.gain_d      <= i_cfg_data[GAIN_BITS-1:0];
                CFG_SETTLE:   r_cfg.settle_band <= i_cfg_data[BAND_W-1:0];
                CFG_TICK_LIM: r_cfg.tick_limit  <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_target = r_target;
    assign o_cfg    = r_cfg;

endmodule

// File: hdl/ppr_term.sv
// one scaled pid term: value times fixed point gain, truncated toward zero
// depends on ppr_pkg
module ppr_term #(
    parameter int VAL_W     = 25,
    parameter int FRAC_BITS = 16
) (
    input  logic signed [VAL_W-1:0]                           i_value,
    input  logic signed [ppr_pkg::GAIN_BITS-1:0]              i_gain,
    output logic signed [VAL_W+ppr_pkg::GAIN_BITS-FRAC_BITS-1:0] o_term
);
    import ppr_pkg::*;

    localparam int PROD_W = VAL_W + GAIN_BITS;
    localparam int TERM_W = PROD_W - FRAC_BITS;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [TERM_W-1:0] w_floor;
    logic                     w_bump;

    assign w_prod  = i_value * i_gain;
    assign w_floor = w_prod[PROD_W-1:FRAC_BITS];
    // negative with a fraction left over: floor is one below the truncated value
    assign w_bump  = w_prod[PROD_W-1] && (|w_prod[FRAC_BITS-1:0]);
    assign o_term  = w_floor + $signed({{(TERM_W-1){1'b0}}, w_bump});

endmodule

// File: hdl/pid_position_regulator_top.sv
// pid position regulator: an accepted item is held in the input register, then its result in the output register
// one item per cycle sustained while the output is not stalled; the error is formed in the input register,
// and the pid terms, clamps and state update are computed from it and registered into the output register
// synchronous active-low reset: idle, integral and tick count zero, settle band 800,
// tick limit 1000, target, gains and previous error zero; no results pending
module pid_position_regulator_top #(
    parameter int POSITION_BITS      = 24,
    parameter int GAIN_FRACTION_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write port
    input  logic                                     i_cfg_we,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]            i_cfg_idx,
    input  logic [((POSITION_BITS > ppr_pkg::GAIN_BITS) ?
                   POSITION_BITS : ppr_pkg::GAIN_BITS)-1:0] i_cfg_data,
    // input item channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_stall,
    input  logic                                     i_start_req,
    input  logic signed [POSITION_BITS-1:0]          i_position,
    // result item channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_stall,
    output logic signed [ppr_pkg::DRIVE_W-1:0]       o_drive,
    output logic                                     o_done_res,
    output logic                                     o_timed_out,
    output logic signed [POSITION_BITS:0]            o_error_out
);
    import ppr_pkg::*;

`include "pid_position_regulator_top_macros.svh"

    localparam int CFG_W  = (POSITION_BITS > GAIN_BITS) ? POSITION_BITS : GAIN_BITS;
    localparam int E_W    = POSITION_BITS + 1;               // error width
    localparam int D_W    = E_W + 1;                         // derivative / integral sum width
    localparam int MAG_W  = (E_W > BAND_W) ? E_W : BAND_W;   // band compare width
    localparam int P_TW   = E_W + GAIN_BITS - GAIN_FRACTION_BITS;
    localparam int I_TW   = INT_W + GAIN_BITS - GAIN_FRACTION_BITS;
    localparam int D_TW   = D_W + GAIN_BITS - GAIN_FRACTION_BITS;
    localparam int SUM_W  = D_TW + 2;

    localparam logic signed [D_W-1:0]   I_HI    = D_W'(INTEGRAL_LIMIT);
    localparam logic signed [D_W-1:0]   I_LO    = D_W'(-INTEGRAL_LIMIT);
    localparam logic signed [INT_W-1:0] I_HI_N  = INT_W'(INTEGRAL_LIMIT);
    localparam logic signed [INT_W-1:0] I_LO_N  = INT_W'(-INTEGRAL_LIMIT);
    localparam logic signed [SUM_W-1:0] S_HI    = SUM_W'(DRIVE_LIMIT);
    localparam logic signed [SUM_W-1:0] S_LO    = SUM_W'(-DRIVE_LIMIT);

    // configuration
    logic signed [POSITION_BITS-1:0] w_target;
    t_cfg                            w_cfg;

    ppr_cfg_regs #(
        .POSITION_BITS (POSITION_BITS),
        .CFG_W         (CFG_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_target   (w_target),
        .o_cfg      (w_cfg)
    );

    // handshake: stage 1 moves into the output register when that register is empty or its result is taken
    logic r_v1, r_v2;
    logic w_adv2, w_acc1;

    assign w_adv2     = r_v1 && (!r_v2 || !i_out_stall);
    assign w_acc1     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_v1 && !w_adv2;

    // stage 1: accepted item with its error already formed
    logic                  r_start;
    logic signed [E_W-1:0] r_err;
    logic signed [E_W-1:0] n_err;

    assign n_err = {i_position[POSITION_BITS-1], i_position}
                 - {w_target[POSITION_BITS-1], w_target};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_acc1) begin
            r_v1 <= 1'b1;
        end else if (w_adv2) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc1) begin
            r_start <= i_start_req;
            r_err   <= n_err;
        end
    end

    // move state
    logic                    r_running;
    logic signed [E_W-1:0]   r_prev;
    logic signed [INT_W-1:0] r_integral;
    logic [TICK_W-1:0]       r_ticks;

    // a start request clears the move state before this tick is evaluated
    logic                    w_run;
    logic signed [E_W-1:0]   w_prev;
    logic signed [INT_W-1:0] w_int;
    logic [TICK_W-1:0]       w_ticks;

    assign w_run   = r_start || r_running;
    assign w_prev  = r_start ? r_err : r_prev;
    assign w_int   = r_start ? '0 : r_integral;
    assign w_ticks = r_start ? '0 : r_ticks;

    // end-of-move checks
    logic [E_W-1:0] w_mag;
    logic           w_settled, w_timeout, w_driving;

    assign w_mag     = r_err[E_W-1] ? E_W'(-r_err) : E_W'(r_err);
    assign w_settled = MAG_W'(w_mag) <= MAG_W'(w_cfg.settle_band);
    assign w_timeout = w_ticks >= w_cfg.tick_limit;
    assign w_driving = w_run && !(w_settled || w_timeout);

    // integral update with clamp
    logic signed [D_W-1:0]   w_int_sum;
    logic signed [INT_W-1:0] n_integral;

    assign w_int_sum = {{(D_W-INT_W){w_int[INT_W-1]}}, w_int} + {r_err[E_W-1], r_err};

    always_comb begin
        if (w_int_sum > I_HI) begin
            n_integral = I_HI_N;
        end else if (w_int_sum < I_LO) begin
            n_integral = I_LO_N;
        end else begin
            n_integral = w_int_sum[INT_W-1:0];
        end
    end

    // derivative; zero on the start tick since the previous error is this error
    logic signed [D_W-1:0] w_diff;
    assign w_diff = {r_err[E_W-1], r_err} - {w_prev[E_W-1], w_prev};

    // the three scaled terms
    logic signed [P_TW-1:0] w_p_term;
    logic signed [I_TW-1:0] w_i_term;
    logic signed [D_TW-1:0] w_d_term;

    ppr_term #(.VAL_W(E_W), .FRAC_BITS(GAIN_FRACTION_BITS)) u_p_term (
        .i_value (r_err),
        .i_gain  (w_cfg.gain_p),
        .o_term  (w_p_term)
    );

    ppr_term #(.VAL_W(INT_W), .FRAC_BITS(GAIN_FRACTION_BITS)) u_i_term (
        .i_value (n_integral),
        .i_gain  (w_cfg.gain_i),
        .o_term  (w_i_term)
    );

    ppr_term #(.VAL_W(D_W), .FRAC_BITS(GAIN_FRACTION_BITS)) u_d_term (
        .i_value (w_diff),
        .i_gain  (w_cfg.gain_d),
        .o_term  (w_d_term)
    );

    // sum and clamp to the drive range
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [DRIVE_W-1:0] w_speed;

    assign w_sum = {{(SUM_W-P_TW){w_p_term[P_TW-1]}}, w_p_term}
                 + {{(SUM_W-I_TW){w_i_term[I_TW-1]}}, w_i_term}
                 + {{(SUM_W-D_TW){w_d_term[D_TW-1]}}, w_d_term};

    always_comb begin
        if (w_sum > S_HI) begin
            w_speed = DRIVE_W'(DRIVE_LIMIT);
        end else if (w_sum < S_LO) begin
            w_speed = DRIVE_W'(-DRIVE_LIMIT);
        end else begin
            w_speed = w_sum[DRIVE_W-1:0];
        end
    end

    // result fields
    logic signed [DRIVE_W-1:0] n_drive;
    logic                      n_done, n_tout;

    assign n_drive = w_driving ? DRIVE_W'(-w_speed) : '0;
    assign n_done  = !w_driving;
    assign n_tout  = w_run && w_timeout;

    // move state update, only when the item actually leaves stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running  <= 1'b0;
            r_prev     <= '0;
            r_integral <= '0;
            r_ticks    <= '0;
        end else if (w_adv2) begin
            r_running <= w_driving;
            if (w_driving) begin
                r_prev     <= r_err;
                r_integral <= n_integral;
                r_ticks    <= w_ticks + TICK_W'(1);
            end else if (r_start) begin
                // move opened and ended on the same tick
                r_prev     <= r_err;
                r_integral <= '0;
                r_ticks    <= '0;
            end
        end
    end

    // output register
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_done, r_tout;
    logic signed [E_W-1:0]     r_err_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv2) begin
            r_v2 <= 1'b1;
        end else if (!i_out_stall) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_drive   <= n_drive;
            r_done    <= n_done;
            r_tout    <= n_tout;
            r_err_out <= r_err;
        end
    end

    assign o_out_valid = r_v2;
    assign o_drive     = r_drive;
    assign o_done_res  = r_done;
    assign o_timed_out = r_tout;
    assign o_error_out = r_err_out;

    // checks
    `PPR_ASSERT_NOW(a_done_no_drive, o_out_valid && o_done_res, o_drive == '0, "drive while done")
    `PPR_ASSERT_NOW(a_timeout_is_done, o_out_valid && o_timed_out, o_done_res, "timeout not done")
    `PPR_ASSERT_NOW(a_integral_bound, 1'b1, (r_integral <= I_HI_N) && (r_integral >= I_LO_N), "integral out of range")
    `PPR_ASSERT_NEXT(a_drive_keeps_run, w_adv2 && w_driving, r_running && r_v2 && !r_done, "driving item lost the move")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for pid_position_regulator_top: directed rows, then random moves
// depends on ppr_pkg and the regulator rtl; results checked against an in-bench pid predictor
module tb_top;
    import ppr_pkg::*;

    localparam int POS_W         = 24;
    localparam int FRAC_W        = 16;
    localparam int CFG_W         = (POS_W > GAIN_BITS) ? POS_W : GAIN_BITS;
    localparam int CYCLE_LIMIT   = 250000;
    localparam int HOLD_OFF_LEN  = 200;
    localparam int ITEMS_PER_SET = 316;
    localparam int NUM_SETS      = 6;
    localparam int SHOW_MAX      = 10;

    // register indexes that the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // one result item as the block reports it
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      done;
        logic                      timed_out;
        logic signed [POS_W:0]     error;
    } t_tick_result;

    typedef enum logic {ROW_CFG, ROW_TICK} t_row_kind;

    // one row of the directed stimulus
    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
        logic                   start;
        bit                     pinned;
        t_tick_result           want;
    } t_stim_row;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // block inputs, all known from time zero
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_idx   = CFG_TARGET;
    logic [CFG_W-1:0]         i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic                     i_start_req = 1'b0;
    logic signed [POS_W-1:0]  i_position  = '0;
    logic                     i_out_stall = 1'b0;

    // block outputs
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DRIVE_W-1:0] o_drive;
    logic                     o_done_res;
    logic                     o_timed_out;
    logic signed [POS_W:0]    o_error_out;

    pid_position_regulator_top #(
        .POSITION_BITS      (POS_W),
        .GAIN_FRACTION_BITS (FRAC_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_start_req (i_start_req),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .o_done_res  (o_done_res),
        .o_timed_out (o_timed_out),
        .o_error_out (o_error_out)
    );

    always #6 i_clk = ~i_clk;

    // mirror of the control registers, reset values of the block
    logic signed [POS_W-1:0]     ctl_target     = '0;
    logic signed [GAIN_BITS-1:0] ctl_gain_p     = '0;
    logic signed [GAIN_BITS-1:0] ctl_gain_i     = '0;
    logic signed [GAIN_BITS-1:0] ctl_gain_d     = '0;
    logic [BAND_W-1:0]           ctl_settle     = SETTLE_BAND_RST;
    logic [TICK_W-1:0]           ctl_tick_limit = TICK_LIMIT_RST;

    // mirror of the move state
    bit                mv_running  = 1'b0;
    longint            mv_prev_err = 0;
    longint            mv_integral = 0;
    logic [TICK_W-1:0] mv_ticks    = '0;

    // results still owed by the block, oldest first
    t_tick_result awaited_results[$];
    t_stim_row    stim_rows[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int tx_idle_pct    = 11;
    int rx_idle_pct    = 64;
    int hold_off_req   = 0;
    int hold_off_seen  = 0;
    int hold_left      = 0;

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // value times a q7.16 gain, truncated toward zero
    function automatic longint q_term(input longint v, input longint gain);
        return (v * gain) / (longint'(1) <<< FRAC_W);
    endfunction

    // expected result of one control tick; advances the move state
    function automatic t_tick_result predict_tick(input logic start,
                                                  input logic signed [POS_W-1:0] pos);
        t_tick_result r;
        longint       err;
        longint       mag;
        longint       speed;
        bit           expired;
        err = longint'(pos) - longint'(ctl_target);
        mag = (err < 0) ? -err : err;
        r.drive     = '0;
        r.done      = 1'b1;
        r.timed_out = 1'b0;
        r.error     = err[POS_W:0];
        // a start clears the move and zeroes the derivative on this tick
        if (start) begin
            mv_running  = 1'b1;
            mv_integral = 0;
            mv_ticks    = '0;
            mv_prev_err = err;
        end
        if (mv_running) begin
            expired     = (mv_ticks >= ctl_tick_limit);
            r.timed_out = expired;
            if (mag <= longint'(ctl_settle) || expired) begin
                mv_running = 1'b0;
            end else begin
                mv_integral = clamp_to(mv_integral + err, INTEGRAL_LIMIT);
                speed = q_term(err, longint'(ctl_gain_p))
                      + q_term(mv_integral, longint'(ctl_gain_i))
                      + q_term(err - mv_prev_err, longint'(ctl_gain_d));
                speed       = clamp_to(speed, DRIVE_LIMIT);
                r.drive     = DRIVE_W'(-speed);
                r.done      = 1'b0;
                mv_prev_err = err;
                mv_ticks    = mv_ticks + 1'b1;
            end
        end
        return r;
    endfunction

    function automatic longint rand_signed(input int unsigned span);
        return longint'($urandom_range(2 * span, 0)) - longint'(span);
    endfunction

    function automatic t_stim_row row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] data);
        t_stim_row r;
        r = '{ROW_CFG, idx, data, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_stim_row row_tick(input logic start, input logic [CFG_W-1:0] pos);
        t_stim_row r;
        r = '{ROW_TICK, CFG_TARGET, pos, start, 1'b0, '0};
        return r;
    endfunction

    // tick whose result is typed in directly
    function automatic t_stim_row row_pin(input logic start, input logic [CFG_W-1:0] pos,
                                          input int drive, input logic done,
                                          input logic tmo, input longint err);
        t_stim_row r;
        r = '{ROW_TICK, CFG_TARGET, pos, start, 1'b1, '0};
        r.want.drive     = DRIVE_W'(drive);
        r.want.done      = done;
        r.want.timed_out = tmo;
        r.want.error     = err[POS_W:0];
        return r;
    endfunction

    // present one item, hold it until accepted, then record what it should produce
    task automatic send_tick(input logic start, input logic signed [POS_W-1:0] pos,
                             input bit pinned, input t_tick_result want);
        t_tick_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_start_req = start;
        i_position  = pos;
        do @(posedge i_clk); while (o_in_stall);
        // valid stays high; the next call decides between a gap and a new item
        predicted = predict_tick(start, pos);
        awaited_results.push_back(pinned ? want : predicted);
    endtask

    // stop offering items and let every owed result come out
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only called with the block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TARGET:   ctl_target     = data[POS_W-1:0];
            CFG_GAIN_P:   ctl_gain_p     = data[GAIN_BITS-1:0];
            CFG_GAIN_I:   ctl_gain_i     = data[GAIN_BITS-1:0];
            CFG_GAIN_D:   ctl_gain_d     = data[GAIN_BITS-1:0];
            CFG_SETTLE:   ctl_settle     = data[BAND_W-1:0];
            CFG_TICK_LIM: ctl_tick_limit = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // settings for one random set: typical ones, plus the register extremes
    task automatic load_set_config(input int set_no);
        logic [CFG_W-1:0] gp, gi, gd, tgt, band, lim;
        gp   = CFG_W'(rand_signed(8191));
        gi   = CFG_W'(rand_signed(4095));
        gd   = CFG_W'(rand_signed(8191));
        band = CFG_W'($urandom_range(2000, 0));
        lim  = CFG_W'($urandom_range(60, 2));
        tgt  = CFG_W'($urandom());
        case (set_no)
            1: begin
                // largest gains of both signs, band zero, longest move
                gp = 24'h7FFFFF; gi = 24'h800000; gd = 24'h7FFFFF;
                band = '0; lim = 24'h00FFFF; tgt = 24'h800000;
            end
            2: begin
                // very short moves, timeouts dominate
                lim = CFG_W'($urandom_range(3, 0));
            end
            3: begin
                // every register fully random
                gp = CFG_W'($urandom()); gi = CFG_W'($urandom()); gd = CFG_W'($urandom());
                band = CFG_W'($urandom()); lim = CFG_W'($urandom());
            end
            4: begin
                gp = 24'h800000; gi = 24'h7FFFFF; gd = 24'h800000;
                band = CFG_W'($urandom_range(4, 0)); lim = CFG_W'($urandom_range(3, 0));
                tgt = 24'h7FFFFF;
            end
            default: ;
        endcase
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_SETTLE, band);
        write_reg(CFG_TICK_LIM, lim);
    endtask

    // one random set: mostly well-formed moves, some noise and stray starts
    task automatic run_random_set(input int set_no);
        int           sent;
        int           len;
        int           pick;
        longint       offset;
        t_tick_result none;
        none = '0;
        sent = 0;
        while (sent < ITEMS_PER_SET) begin
            pick = $urandom_range(99);
            // long receiver hold-off partway through the first set
            if (set_no == 0 && sent >= 100 && hold_off_req == 0) hold_off_req = 1;
            if (pick < 80) begin
                // a move: start away from the target, then close in with noise
                offset = ($urandom_range(7) == 0) ? rand_signed(8388607) : rand_signed(30000);
                send_tick(1'b1, POS_W'(longint'(ctl_target) + offset), 1'b0, none);
                sent++;
                len = $urandom_range(40, 1);
                for (int k = 0; k < len && sent < ITEMS_PER_SET; k++) begin
                    offset = offset - offset / longint'($urandom_range(6, 2))
                           + rand_signed(300);
                    send_tick($urandom_range(19) == 0,
                              POS_W'(longint'(ctl_target) + offset), 1'b0, none);
                    sent++;
                end
            end else if (pick < 92) begin
                // plain sample with no start, anywhere in range
                send_tick(1'b0, POS_W'($urandom()), 1'b0, none);
                sent++;
            end else begin
                // stray start from anywhere
                send_tick(1'b1, POS_W'($urandom()), 1'b0, none);
                sent++;
            end
        end
    endtask

    // receiver: random stalls, plus a counted hold-off when asked
    always @(negedge i_clk) begin
        if (hold_off_req != hold_off_seen) begin
            hold_off_seen = hold_off_req;
            hold_left     = HOLD_OFF_LEN;
        end
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(99) < rx_idle_pct);
        end
    end

    // result checker: every accepted result against the oldest expectation
    always @(posedge i_clk) begin
        t_tick_result got;
        t_tick_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.drive     = o_drive;
            got.done      = o_done_res;
            got.timed_out = o_timed_out;
            got.error     = o_error_out;
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_MAX)
                    $display("unexpected result: drive %0d done %0b timed_out %0b error %0d",
                             got.drive, got.done, got.timed_out, got.error);
            end else begin
                want = awaited_results.pop_front();
                if (got.drive !== want.drive || got.done !== want.done ||
                    got.timed_out !== want.timed_out || got.error !== want.error) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display({"mismatch: drive %0d/%0d done %0b/%0b ",
                                  "timed_out %0b/%0b error %0d/%0d (expected/actual)"},
                                 want.drive, got.drive, want.done, got.done,
                                 want.timed_out, got.timed_out, want.error, got.error);
                end
            end
        end
    end

    // hard stop on a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        // directed rows; reset state is target 0, gains 0, band 800, limit 1000
        // idle ticks at zero and both position extremes
        stim_rows.push_back(row_pin(1'b0, 24'h000000, 0, 1'b1, 1'b0, 0));
        stim_rows.push_back(row_pin(1'b0, 24'h7FFFFF, 0, 1'b1, 1'b0, 8388607));
        stim_rows.push_back(row_pin(1'b0, 24'h800000, 0, 1'b1, 1'b0, -8388608));
        // error exactly on the band settles at start, one past it runs
        stim_rows.push_back(row_pin(1'b1, 24'(800), 0, 1'b1, 1'b0, 800));
        stim_rows.push_back(row_pin(1'b1, 24'(-801), 0, 1'b0, 1'b0, -801));
        stim_rows.push_back(row_pin(1'b0, 24'(801), 0, 1'b0, 1'b0, 801));
        // gain and target extremes, largest error of both signs
        stim_rows.push_back(row_cfg(CFG_GAIN_P, 24'h7FFFFF));
        stim_rows.push_back(row_cfg(CFG_GAIN_I, 24'h800000));
        stim_rows.push_back(row_cfg(CFG_GAIN_D, 24'h010000));
        stim_rows.push_back(row_cfg(CFG_TARGET, 24'h7FFFFF));
        stim_rows.push_back(row_tick(1'b1, 24'h800000));
        stim_rows.push_back(row_tick(1'b0, 24'h800000));
        stim_rows.push_back(row_cfg(CFG_TARGET, 24'h800000));
        stim_rows.push_back(row_tick(1'b1, 24'h7FFFFF));
        stim_rows.push_back(row_tick(1'b0, 24'h7FFFFF));
        // start while a move runs restarts it
        stim_rows.push_back(row_tick(1'b1, 24'h000000));
        // moderate gains over a short move, drive both unsaturated and clamped
        stim_rows.push_back(row_cfg(CFG_GAIN_P, 24'h001000));
        stim_rows.push_back(row_cfg(CFG_GAIN_I, 24'hFFF000));
        stim_rows.push_back(row_cfg(CFG_GAIN_D, 24'h000800));
        stim_rows.push_back(row_cfg(CFG_TARGET, 24'h000000));
        stim_rows.push_back(row_tick(1'b1, 24'(3000)));
        stim_rows.push_back(row_tick(1'b0, 24'(2500)));
        stim_rows.push_back(row_tick(1'b0, 24'(-1500)));
        stim_rows.push_back(row_tick(1'b0, 24'(900)));
        // tick limit zero: settled and timed out together, then timed out on start
        stim_rows.push_back(row_cfg(CFG_TICK_LIM, 24'h000000));
        stim_rows.push_back(row_pin(1'b1, 24'h000000, 0, 1'b1, 1'b1, 0));
        stim_rows.push_back(row_pin(1'b1, 24'(100000), 0, 1'b1, 1'b1, 100000));
        stim_rows.push_back(row_pin(1'b0, 24'(100000), 0, 1'b1, 1'b0, 100000));
        // band zero, limit two: two driven ticks, then timeout, then idle
        stim_rows.push_back(row_cfg(CFG_TICK_LIM, 24'h000002));
        stim_rows.push_back(row_cfg(CFG_SETTLE, 24'h000000));
        stim_rows.push_back(row_tick(1'b1, 24'(5000)));
        stim_rows.push_back(row_tick(1'b0, 24'(5000)));
        stim_rows.push_back(row_pin(1'b0, 24'(5000), 0, 1'b1, 1'b1, 5000));
        stim_rows.push_back(row_pin(1'b0, 24'(5000), 0, 1'b1, 1'b0, 5000));
        // widest band, upper data bit dropped by the register
        stim_rows.push_back(row_cfg(CFG_SETTLE, 24'hFFFFFF));
        stim_rows.push_back(row_pin(1'b1, 24'h7FFFFF, 0, 1'b1, 1'b0, 8388607));
        stim_rows.push_back(row_tick(1'b1, 24'h800000));
        // longest limit, unused indexes must change nothing
        stim_rows.push_back(row_cfg(CFG_TICK_LIM, 24'hFFFFFF));
        stim_rows.push_back(row_cfg(CFG_SETTLE, 24'(800)));
        stim_rows.push_back(row_cfg(CFG_SPARE_LO, 24'hFFFFFF));
        stim_rows.push_back(row_cfg(CFG_SPARE_HI, 24'h5A5A5A));
        stim_rows.push_back(row_tick(1'b1, 24'(2000)));
        stim_rows.push_back(row_tick(1'b0, 24'(1200)));

        // synchronous reset held, then released at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, sender idles 11 in 100 and receiver 64
        foreach (stim_rows[n]) begin
            if (stim_rows[n].kind == ROW_CFG) begin
                drain_results();
                write_reg(stim_rows[n].idx, stim_rows[n].data);
            end else begin
                send_tick(stim_rows[n].start, stim_rows[n].data[POS_W-1:0],
                          stim_rows[n].pinned, stim_rows[n].want);
            end
        end

        // random sets, two per idling mode
        for (int s = 0; s < NUM_SETS; s++) begin
            case (s / 2)
                0: begin tx_idle_pct = 11; rx_idle_pct = 64; end
                1: begin tx_idle_pct = 64; rx_idle_pct = 11; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            drain_results();
            load_set_config(s);
            run_random_set(s);
        end

        // let the last results out, then give the verdict
        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
